// File: rtl/core/afs_pkg.sv
package afs_pkg;

	localparam int NUM_CH = 4;
	localparam int WAVE_CH = 2;

	localparam logic [17:0] SAMPLE_RATE_RESET = 18'd48000;
	localparam logic [18:0] PHASE_INC = 19'd512;
	localparam logic [3:0] VOLUME_MAX = 4'hF;

	// Command codes carried in the command field of a beat.
	localparam logic [2:0] CMD_TICK = 3'd0;
	localparam logic [2:0] CMD_SET_SWEEP = 3'd1;
	localparam logic [2:0] CMD_SET_LENGTH = 3'd2;
	localparam logic [2:0] CMD_LENGTH_EN = 3'd3;
	localparam logic [2:0] CMD_SET_ENVELOPE = 3'd4;
	localparam logic [2:0] CMD_TRIGGER = 3'd5;

	// Wave channel volume codes, taken from bits 7..5 of the envelope byte.
	localparam logic [2:0] WAVE_CODE_MUTE = 3'd0;
	localparam logic [2:0] WAVE_CODE_FULL = 3'd1;
	localparam logic [2:0] WAVE_CODE_HALF = 3'd2;
	localparam logic [2:0] WAVE_CODE_QUARTER = 3'd3;
	localparam logic [2:0] WAVE_CODE_THREE_Q = 3'd4;

	localparam logic [2:0] WAVE_VOL_MUTE = 3'd0;
	localparam logic [2:0] WAVE_VOL_QUARTER = 3'd1;
	localparam logic [2:0] WAVE_VOL_HALF = 3'd2;
	localparam logic [2:0] WAVE_VOL_THREE_Q = 3'd3;
	localparam logic [2:0] WAVE_VOL_FULL = 3'd4;

	typedef struct packed {
		logic [2:0]  command;
		logic [1:0]  channel;
		logic [7:0]  value;
		logic [10:0] freq_reg;
	} cmd_t;

	typedef struct packed {
		logic [3:0]  volume0;
		logic [3:0]  volume1;
		logic [2:0]  volume2;
		logic [3:0]  volume3;
		logic [3:0]  dac_mask;
		logic [3:0]  length_stop_mask;
		logic        freq_write;
		logic [10:0] new_freq;
	} result_t;

endpackage

// File: rtl/core/afs_stream_if.sv
interface afs_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

// File: rtl/core/apu_frame_sequencer.sv
// Frame sequencer and channel control of a four-channel sound unit.
// The cmd channel takes one beat per register write or per sample tick
// (command 0). The result channel returns exactly one beat per cmd beat,
// in order: the volumes of all channels, the DAC enable mask, the channels
// whose length counter ran out on this tick, and a swept frequency for
// channel 0 together with its write strobe.
// sample_rate is written through sample_rate_we / sample_rate_wdata; it sets
// how many ticks make one sequencer step. The user must write it only while
// the block is idle; the block does not enforce this. A beat is captured in an
// input register; one pass of short logic then updates all state and loads the
// result register when it is free or being drained. One beat can be taken
// every cycle while the receiver does not stall, set by that single
// register-to-register pass. When the receiver stalls, the result register
// holds its beat and one more cmd beat waits in the input register; after
// that cmd.ready drops. Reset (arst_n low) clears all sequencer, length, envelope
// and sweep state, empties both registers and loads sample_rate with 48000.
module apu_frame_sequencer (
	input  logic                clk,
	input  logic                arst_n,
	afs_stream_if.sink          cmd,
	afs_stream_if.source        result,
	input  logic                sample_rate_we,
	input  logic [17:0]         sample_rate_wdata
);

	localparam int NC = afs_pkg::NUM_CH;

	// Input stage and result register.
	logic             in_valid_s1;
	afs_pkg::cmd_t    in_s1;
	logic             res_valid_q;
	afs_pkg::result_t res_q;
	logic             adv;

	logic [17:0] sample_rate_q;

	// Sequencer and per-channel state.
	logic [17:0] phase_acc_q, phase_acc_n;
	logic [2:0]  step_q, step_n;
	logic [7:0]  length_count_q [NC], length_count_n [NC];
	logic [7:0]  length_load_q [NC], length_load_n [NC];
	logic        length_en_q [NC], length_en_n [NC];
	logic [3:0]  volume_q [NC], volume_n [NC];
	logic [3:0]  volume_load_q [NC], volume_load_n [NC];
	logic [2:0]  env_count_q [NC], env_count_n [NC];
	logic [2:0]  env_period_q [NC], env_period_n [NC];
	logic        env_up_q [NC], env_up_n [NC];
	logic        dac_on_q [NC], dac_on_n [NC];
	logic        sweep_down_q, sweep_down_n;
	logic [2:0]  sweep_count_q, sweep_count_n;
	logic [2:0]  sweep_period_q, sweep_period_n;
	logic [2:0]  sweep_shift_q, sweep_shift_n;

	afs_pkg::result_t res_n;

	// The input register frees up whenever its beat moves on to the result register,
	// which may happen in the same cycle the result register is drained.
	assign adv = in_valid_s1 && (!res_valid_q || result.ready);
	assign cmd.ready = !in_valid_s1 || adv;
	assign result.valid = res_valid_q;
	assign result.data = res_q;

	always_comb begin
		logic [18:0] sum;
		logic [2:0]  env_dec;
		logic [2:0]  sw_dec;
		logic [10:0] f;
		logic [10:0] f_shift;
		logic [11:0] f_sum;
		logic [3:0]  stop;
		logic        wr;
		logic [10:0] nf;
		logic [3:0]  dm;
		logic [1:0]  ch;
		logic [7:0]  v;

		phase_acc_n = phase_acc_q;
		step_n = step_q;
		length_count_n = length_count_q;
		length_load_n = length_load_q;
		length_en_n = length_en_q;
		volume_n = volume_q;
		volume_load_n = volume_load_q;
		env_count_n = env_count_q;
		env_period_n = env_period_q;
		env_up_n = env_up_q;
		dac_on_n = dac_on_q;
		sweep_down_n = sweep_down_q;
		sweep_count_n = sweep_count_q;
		sweep_period_n = sweep_period_q;
		sweep_shift_n = sweep_shift_q;

		sum = '0;
		env_dec = '0;
		sw_dec = '0;
		f = '0;
		f_shift = '0;
		f_sum = '0;
		stop = '0;
		wr = 1'b0;
		nf = '0;
		dm = '0;
		ch = in_s1.channel;
		v = in_s1.value;

		case (in_s1.command)
			afs_pkg::CMD_TICK: begin
				sum = {1'b0, phase_acc_q} + afs_pkg::PHASE_INC;
				if (sum >= {1'b0, sample_rate_q}) begin
					sum = sum - {1'b0, sample_rate_q};
					step_n = step_q + 3'd1;

					// Length counters run on every even step.
					if (!step_n[0]) begin
						for (int c = 0; c < NC; c++) begin
							if (length_count_q[c] != 8'd0) begin
								length_count_n[c] = length_count_q[c] - 8'd1;
								if (length_count_q[c] == 8'd1 && length_en_q[c])
									stop[c] = 1'b1;
							end
						end
					end

					// Envelopes run on step 7; the wave channel has none.
					if (step_n == 3'd7) begin
						for (int c = 0; c < NC; c++) begin
							env_dec = env_count_q[c] - 3'd1;
							if (c != afs_pkg::WAVE_CH && env_count_q[c] != 3'd0) begin
								env_count_n[c] = env_dec;
								if (env_dec == 3'd0) begin
									if (volume_q[c] != 4'd0 && !env_up_q[c]) begin
										volume_n[c] = volume_q[c] - 4'd1;
										env_count_n[c] = env_period_q[c];
									end else if (volume_q[c] < afs_pkg::VOLUME_MAX && env_up_q[c]) begin
										volume_n[c] = volume_q[c] + 4'd1;
										env_count_n[c] = env_period_q[c];
									end
								end
							end
						end
					end

					// Channel 0 sweep runs on steps 2 and 6.
					if (step_n[1:0] == 2'b10 && sweep_period_q != 3'd0 &&
					    sweep_shift_q != 3'd0) begin
						sw_dec = sweep_count_q - 3'd1;
						sweep_count_n = sw_dec;
						if (sw_dec == 3'd0) begin
							f = in_s1.freq_reg;
							f_shift = f >> sweep_shift_q;
							if (sweep_down_q)
								f_sum = {1'b0, f} - {1'b0, f_shift};
							else
								f_sum = {1'b0, f} + {1'b0, f_shift};
							if (!sweep_down_q && f_sum[11]) begin
								// Overflow past the 11-bit range mutes channel 0.
								nf = '0;
								env_count_n[0] = 3'd0;
								volume_n[0] = 4'd0;
							end else begin
								nf = f_sum[10:0];
							end
							wr = 1'b1;
							sweep_count_n = sweep_period_q;
						end
					end
				end
				phase_acc_n = sum[17:0];
			end
			afs_pkg::CMD_SET_SWEEP: begin
				sweep_down_n = v[3];
				sweep_period_n = v[6:4];
				sweep_count_n = v[6:4];
				sweep_shift_n = v[2:0];
			end
			afs_pkg::CMD_SET_LENGTH: begin
				length_count_n[ch] = v;
				length_load_n[ch] = v;
			end
			afs_pkg::CMD_LENGTH_EN: begin
				length_en_n[ch] = v[0];
			end
			afs_pkg::CMD_SET_ENVELOPE: begin
				if (ch == 2'(afs_pkg::WAVE_CH)) begin
					// Unknown wave codes leave the volume untouched.
					case (v[7:5])
						afs_pkg::WAVE_CODE_MUTE: begin
							volume_n[ch] = {1'b0, afs_pkg::WAVE_VOL_MUTE};
							volume_load_n[ch] = {1'b0, afs_pkg::WAVE_VOL_MUTE};
						end
						afs_pkg::WAVE_CODE_FULL: begin
							volume_n[ch] = {1'b0, afs_pkg::WAVE_VOL_FULL};
							volume_load_n[ch] = {1'b0, afs_pkg::WAVE_VOL_FULL};
						end
						afs_pkg::WAVE_CODE_HALF: begin
							volume_n[ch] = {1'b0, afs_pkg::WAVE_VOL_HALF};
							volume_load_n[ch] = {1'b0, afs_pkg::WAVE_VOL_HALF};
						end
						afs_pkg::WAVE_CODE_QUARTER: begin
							volume_n[ch] = {1'b0, afs_pkg::WAVE_VOL_QUARTER};
							volume_load_n[ch] = {1'b0, afs_pkg::WAVE_VOL_QUARTER};
						end
						afs_pkg::WAVE_CODE_THREE_Q: begin
							volume_n[ch] = {1'b0, afs_pkg::WAVE_VOL_THREE_Q};
							volume_load_n[ch] = {1'b0, afs_pkg::WAVE_VOL_THREE_Q};
						end
						default: begin
						end
					endcase
				end else begin
					dac_on_n[ch] = |v[7:3];
					volume_n[ch] = v[7:4];
					volume_load_n[ch] = v[7:4];
					env_up_n[ch] = v[3];
					env_count_n[ch] = v[2:0];
					env_period_n[ch] = v[2:0];
				end
			end
			afs_pkg::CMD_TRIGGER: begin
				volume_n[ch] = volume_load_q[ch];
				length_count_n[ch] = length_load_q[ch];
				if (ch != 2'(afs_pkg::WAVE_CH))
					env_count_n[ch] = env_period_q[ch];
			end
			default: begin
			end
		endcase

		for (int c = 0; c < NC; c++)
			dm[c] = dac_on_n[c];

		res_n.volume0 = volume_n[0];
		res_n.volume1 = volume_n[1];
		res_n.volume2 = volume_n[2][2:0];
		res_n.volume3 = volume_n[3];
		res_n.dac_mask = dm;
		res_n.length_stop_mask = stop;
		res_n.freq_write = wr;
		res_n.new_freq = nf;
	end

	// Handshake control and configuration.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
			res_valid_q <= 1'b0;
			sample_rate_q <= afs_pkg::SAMPLE_RATE_RESET;
		end else begin
			if (cmd.valid && cmd.ready)
				in_valid_s1 <= 1'b1;
			else if (adv)
				in_valid_s1 <= 1'b0;

			if (adv)
				res_valid_q <= 1'b1;
			else if (result.ready)
				res_valid_q <= 1'b0;

			if (sample_rate_we)
				sample_rate_q <= sample_rate_wdata;
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (cmd.valid && cmd.ready)
			in_s1 <= cmd.data;
		if (adv)
			res_q <= res_n;
	end

	// Channel state advances once per beat leaving the input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_acc_q <= '0;
			step_q <= '0;
			sweep_down_q <= 1'b0;
			sweep_count_q <= '0;
			sweep_period_q <= '0;
			sweep_shift_q <= '0;
			for (int c = 0; c < NC; c++) begin
				length_count_q[c] <= '0;
				length_load_q[c] <= '0;
				length_en_q[c] <= 1'b0;
				volume_q[c] <= '0;
				volume_load_q[c] <= '0;
				env_count_q[c] <= '0;
				env_period_q[c] <= '0;
				env_up_q[c] <= 1'b0;
				dac_on_q[c] <= 1'b0;
			end
		end else if (adv) begin
			phase_acc_q <= phase_acc_n;
			step_q <= step_n;
			sweep_down_q <= sweep_down_n;
			sweep_count_q <= sweep_count_n;
			sweep_period_q <= sweep_period_n;
			sweep_shift_q <= sweep_shift_n;
			length_count_q <= length_count_n;
			length_load_q <= length_load_n;
			length_en_q <= length_en_n;
			volume_q <= volume_n;
			volume_load_q <= volume_load_n;
			env_count_q <= env_count_n;
			env_period_q <= env_period_n;
			env_up_q <= env_up_n;
			dac_on_q <= dac_on_n;
		end
	end

endmodule
